// ----- sv/srd_pkg.sv -----
package srd_pkg;

	// fixed number formats of the stick datapath
	localparam int AXIS_LIMIT    = 127;
	localparam int FRACTION_BITS = 14;
	localparam int AXIS_W        = 8;
	localparam int LIM_W         = $clog2(AXIS_LIMIT + 1);
	localparam int SQ_W          = 2 * LIM_W;
	localparam int SUM_W         = SQ_W + 1;
	localparam int EW            = 2 * FRACTION_BITS + 2 * LIM_W + 8;
	localparam int Q_W           = FRACTION_BITS + 1;
	localparam int STEPS         = Q_W;
	localparam int DIR_W         = 16;
	localparam int MAG_W         = 15;
	localparam int DZ_W          = 7;
	localparam int IN_W          = 2 * AXIS_W;
	localparam int OUT_W         = 2 * DIR_W + MAG_W + 1;
	localparam int LIM_SQ        = AXIS_LIMIT * AXIS_LIMIT;
	localparam int DZ_MAX        = AXIS_LIMIT - 1;
	localparam int DZ_RESET      = 31;

	// one digit-recurrence search: residual, running product, quotient so far
	typedef struct packed {
		logic signed [EW-1:0] e;
		logic signed [EW-1:0] p;
		logic [Q_W-1:0]       q;
	} search_t;

	// one sample in flight through the search stages
	typedef struct packed {
		logic            vld;
		logic            neg_x;
		logic            neg_y;
		logic            outside;
		logic [SQ_W-1:0] msq;
		logic [SQ_W-1:0] dsq;
		search_t         sx;
		search_t         sy;
		search_t         sm;
	} lane_t;

endpackage

// ----- sv/stick_radial_deadzone.sv -----
// Radial deadzone for a two-axis stick.
// Input stream s_*: one beat per sample, tdata = {stick_y, stick_x}, each 8-bit two's
// complement, clamped inside to +/-127.
// Output stream m_*: one beat per sample, tdata = {outside_deadzone, magnitude_scale,
// dir_y, dir_x}; dir_* are Q1.14 signed, magnitude_scale is Q1.14 unsigned.
// Config channel cfg_*: writes the 7-bit deadzone radius (values above 126 act as 126);
// cfg_ready is always high, write only while no sample is in flight.
// From input beat to output beat a sample passes one stage for clamping and squares,
// one for the deadzone test and search setup, fifteen stages of the bit-per-stage
// root-and-divide searches (one quotient bit each) and one output register.
// Throughput is one sample per cycle unless the output stalls; every stage holds one sample.
// Reset clears all valid bits and loads a deadzone radius of 31.
// When the receiver holds m_tready low with a result waiting, the whole pipeline
// freezes and s_tready drops; nothing is lost or repeated. The pipeline always moves
// as one, so bubbles inside it are never squeezed out.
module stick_radial_deadzone (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [srd_pkg::IN_W-1:0]   s_tdata,   // stick_x, stick_y
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [srd_pkg::OUT_W-1:0]  m_tdata,   // dir_x, dir_y, magnitude_scale, outside_deadzone
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [srd_pkg::DZ_W-1:0]   cfg_data
);

	localparam int F  = srd_pkg::FRACTION_BITS;
	localparam int EW = srd_pkg::EW;

	logic                      adv;
	logic [srd_pkg::DZ_W-1:0]  dz_q;

	// deadzone register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= srd_pkg::DZ_W'(srd_pkg::DZ_RESET);
		end else if (cfg_valid) begin
			dz_q <= cfg_data;
		end
	end

	// whole pipeline moves when the output register can take a beat
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1: clamp, absolute values, squares
	logic signed [srd_pkg::AXIS_W-1:0] sx_in, sy_in;
	logic [srd_pkg::LIM_W-1:0]         ax, ay, dzs, dd;
	logic                              vld_s1, negx_s1, negy_s1;
	logic [srd_pkg::SQ_W-1:0]          xsq_s1, ysq_s1, dzsq_s1, dzd_s1, dsq_s1;

	assign sx_in = signed'(s_tdata[srd_pkg::AXIS_W-1:0]);
	assign sy_in = signed'(s_tdata[srd_pkg::IN_W-1:srd_pkg::AXIS_W]);

	always_comb begin
		ax = sx_in[srd_pkg::AXIS_W-1] ? srd_pkg::LIM_W'(-sx_in) : srd_pkg::LIM_W'(sx_in);
		ay = sy_in[srd_pkg::AXIS_W-1] ? srd_pkg::LIM_W'(-sy_in) : srd_pkg::LIM_W'(sy_in);
		if (sx_in == -8'sd128) ax = srd_pkg::LIM_W'(srd_pkg::AXIS_LIMIT);
		if (sy_in == -8'sd128) ay = srd_pkg::LIM_W'(srd_pkg::AXIS_LIMIT);
		dzs = (dz_q > srd_pkg::DZ_W'(srd_pkg::DZ_MAX)) ? srd_pkg::LIM_W'(srd_pkg::DZ_MAX)
		                                                : srd_pkg::LIM_W'(dz_q);
		dd  = srd_pkg::LIM_W'(srd_pkg::AXIS_LIMIT) - dzs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			negx_s1 <= sx_in[srd_pkg::AXIS_W-1];
			negy_s1 <= sy_in[srd_pkg::AXIS_W-1];
			xsq_s1  <= ax * ax;
			ysq_s1  <= ay * ay;
			dzsq_s1 <= dzs * dzs;
			dzd_s1  <= dzs * dd;
			dsq_s1  <= dd * dd;
		end
	end

	// stage 2: deadzone test, magnitude cap, search setup
	logic [srd_pkg::SUM_W-1:0] sumsq;
	logic [srd_pkg::SQ_W-1:0]  msq;
	srd_pkg::lane_t            ld;
	srd_pkg::lane_t            stg_s [0:srd_pkg::STEPS];

	assign sumsq = srd_pkg::SUM_W'(xsq_s1) + srd_pkg::SUM_W'(ysq_s1);
	assign msq   = (sumsq > srd_pkg::SUM_W'(srd_pkg::LIM_SQ)) ? srd_pkg::SQ_W'(srd_pkg::LIM_SQ)
	                                                           : srd_pkg::SQ_W'(sumsq);

	always_comb begin
		ld.vld     = vld_s1;
		ld.neg_x   = negx_s1;
		ld.neg_y   = negy_s1;
		ld.outside = srd_pkg::SUM_W'(dzsq_s1) < sumsq;
		ld.msq     = msq;
		ld.dsq     = dsq_s1;
		ld.sx.e    = (EW'(xsq_s1) <<< (2 * F + 2)) - EW'(msq);
		ld.sx.p    = -EW'(msq);
		ld.sx.q    = '0;
		ld.sy.e    = (EW'(ysq_s1) <<< (2 * F + 2)) - EW'(msq);
		ld.sy.p    = -EW'(msq);
		ld.sy.q    = '0;
		ld.sm.e    = ((EW'(msq) - EW'(dzsq_s1)) <<< (2 * F + 2))
		           + (EW'(dzd_s1) <<< (F + 2)) - EW'(dsq_s1);
		ld.sm.p    = (EW'(dzd_s1) <<< (F + 1)) - EW'(dsq_s1);
		ld.sm.q    = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_s[0].vld <= 1'b0;
		end else if (adv) begin
			stg_s[0] <= ld;
		end
	end

	// search stages: one quotient bit per stage, most significant first
	for (genvar gi = 0; gi < srd_pkg::STEPS; gi++) begin : g_step
		srd_pkg::lane_t nx;

		srd_root_step #(.K(srd_pkg::STEPS - 1 - gi)) u_x (
			.unit (stg_s[gi].msq),
			.cur  (stg_s[gi].sx),
			.nxt  (nx.sx)
		);
		srd_root_step #(.K(srd_pkg::STEPS - 1 - gi)) u_y (
			.unit (stg_s[gi].msq),
			.cur  (stg_s[gi].sy),
			.nxt  (nx.sy)
		);
		srd_root_step #(.K(srd_pkg::STEPS - 1 - gi)) u_m (
			.unit (stg_s[gi].dsq),
			.cur  (stg_s[gi].sm),
			.nxt  (nx.sm)
		);

		assign nx.vld     = stg_s[gi].vld;
		assign nx.neg_x   = stg_s[gi].neg_x;
		assign nx.neg_y   = stg_s[gi].neg_y;
		assign nx.outside = stg_s[gi].outside;
		assign nx.msq     = stg_s[gi].msq;
		assign nx.dsq     = stg_s[gi].dsq;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_s[gi+1].vld <= 1'b0;
			end else if (adv) begin
				stg_s[gi+1] <= nx;
			end
		end
	end

	// output register: sign, zeroing inside the deadzone, packing
	srd_pkg::lane_t              fin;
	logic [srd_pkg::DIR_W-1:0]   dx, dy, ux, uy;
	logic [srd_pkg::MAG_W-1:0]   mg;
	logic                        m_tvalid_q;
	logic [srd_pkg::OUT_W-1:0]   m_tdata_q;

	assign fin = stg_s[srd_pkg::STEPS];
	assign ux  = srd_pkg::DIR_W'(fin.sx.q);
	assign uy  = srd_pkg::DIR_W'(fin.sy.q);
	assign dx  = !fin.outside ? '0 : (fin.neg_x ? -ux : ux);
	assign dy  = !fin.outside ? '0 : (fin.neg_y ? -uy : uy);
	assign mg  = fin.outside ? srd_pkg::MAG_W'(fin.sm.q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= fin.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= {fin.outside, mg, dy, dx};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- sv/srd_root_step.sv -----
module srd_root_step #(
	parameter int K = 0
) (
	input  logic [srd_pkg::SQ_W-1:0] unit,
	input  srd_pkg::search_t         cur,
	output srd_pkg::search_t         nxt
);

	logic signed [srd_pkg::EW-1:0] u_ext;
	logic signed [srd_pkg::EW-1:0] dlt;

	assign u_ext = signed'({{(srd_pkg::EW - srd_pkg::SQ_W){1'b0}}, unit});

	// growth of the squared term when bit K of the quotient is set
	assign dlt = (cur.p <<< (K + 2)) + (u_ext <<< (2 * K + 2));

	// keep the bit when the residual stays non-negative
	always_comb begin
		nxt = cur;
		if (dlt <= cur.e) begin
			nxt.e = cur.e - dlt;
			nxt.p = cur.p + (u_ext <<< (K + 1));
			nxt.q = cur.q | (srd_pkg::Q_W'(1) << K);
		end
	end

endmodule

// ----- sv/srd_check.sv -----
module srd_check (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [srd_pkg::OUT_W-1:0]  m_tdata,
	input logic                       cfg_ready
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// inside the deadzone every field is zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[srd_pkg::OUT_W-1] |-> m_tdata == '0)
		else $error("nonzero result inside deadzone");

	// rescaled magnitude never exceeds 1.0
	a_mag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[srd_pkg::OUT_W-2:2*srd_pkg::DIR_W] <= 15'd16384)
		else $error("magnitude above unity");

	// input side is open whenever the output register is free
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready && cfg_ready)
		else $error("input blocked with free output");

endmodule

bind stick_radial_deadzone srd_check u_srd_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_ready (cfg_ready)
);
